>>> rtl/utce_pkg.sv
// Package: shared types, calendar constants and helpers for the UTC to epoch unit.
package utce_pkg;

   // Number of register stages from request word to response word.
   localparam int NUM_STAGES = 12;

   // First and last of the month-adjust stages.
   localparam int MSTEP_FIRST = 3;
   localparam int MSTEP_LAST  = 7;

   localparam int SEC_PER_MIN     = 60;
   localparam int MIN_PER_HOUR    = 60;
   localparam int HOUR_PER_DAY    = 24;
   localparam int SEC_PER_HOUR    = 3600;
   localparam int SEC_PER_DAY     = 86400;
   localparam int MONTHS_PER_YEAR = 12;
   localparam int DAYS_PER_YEAR   = 365;
   localparam int DAYS_PER_WEEK   = 7;

   // Years are carried as year minus 1900.
   localparam int EPOCH_YEAR_OFS = 70;
   // s = year - 1 as a full year, taken as a plain positive count.
   localparam int YEAR_M1_BASE   = 1899;
   // (1969 / 4) minus the century correction for 1901 onwards.
   localparam int LEAP_BASE      = 491;
   localparam int CENTURY_1900   = 0;
   localparam int CENTURY_2000   = 100;
   localparam int CENTURY_2100   = 200;

   // 1970-01-01 was a Thursday; bias keeps the weekday sum positive.
   localparam int WDAY_EPOCH = 4;
   localparam int WDAY_BIAS  = 35000;

   localparam logic [3:0] MONTH_JAN = 4'd0;
   localparam logic [3:0] MONTH_FEB = 4'd1;
   localparam logic [3:0] MONTH_DEC = 4'd11;

   localparam logic [8:0] CUM_DAYS [13] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
   };

   // Working word carried down the pipeline.
   typedef struct packed {
      logic signed [9:0]  yr;      // year minus 1900
      logic [3:0]         mo;
      logic signed [8:0]  dy;      // day of month from 0
      logic signed [8:0]  hr;
      logic signed [9:0]  mn;
      logic [5:0]         sc;
      logic [8:0]         yday;
      logic signed [8:0]  ydiff;
      logic signed [6:0]  leapd;
      logic [16:0]        tod;
      logic               pre_epoch;
      logic signed [17:0] total;
      logic [31:0]        prod;
      logic [5:0]         wfold;
      logic [31:0]        secs;
      logic [2:0]         wday;
   } item_type;

   // Gregorian leap rule. The only century years the carried range reaches
   // are 1900, 2000 and 2100, of which 2000 alone is a leap year.
   function automatic logic is_leap(input logic signed [9:0] yr);
      return (yr[1:0] == 2'b00) && (yr != 10'(CENTURY_1900)) &&
             (yr != 10'(CENTURY_2100));
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] mo,
                                            input logic signed [9:0] yr);
      logic [3:0] nxt;
      nxt = 4'(mo + 4'd1);
      return 5'(int'(CUM_DAYS[nxt]) - int'(CUM_DAYS[mo]) +
                ((mo == MONTH_FEB && is_leap(yr)) ? 1 : 0));
   endfunction

endpackage

>>> rtl/utce_req_if.sv
// Interface: request channel carrying one broken-down UTC time per word.
interface utce_req_if;
   logic              valid;
   logic              ready;
   logic [7:0]        year_since_1900;
   logic signed [6:0] month_raw;
   logic signed [7:0] day_of_month_raw;
   logic signed [7:0] hour_raw;
   logic signed [8:0] minute_raw;
   logic signed [8:0] second_raw;

   modport source (
      output valid, year_since_1900, month_raw, day_of_month_raw,
             hour_raw, minute_raw, second_raw,
      input  ready
   );
   modport sink (
      input  valid, year_since_1900, month_raw, day_of_month_raw,
             hour_raw, minute_raw, second_raw,
      output ready
   );
endinterface

>>> rtl/utce_rsp_if.sv
// Interface: response channel carrying the normalised time and epoch seconds.
interface utce_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [9:0] year_norm;
   logic [3:0]        month_norm;
   logic [4:0]        day_norm;
   logic [4:0]        hour_norm;
   logic [5:0]        minute_norm;
   logic [5:0]        second_norm;
   logic [8:0]        day_of_year;
   logic [2:0]        weekday;
   logic [31:0]       epoch_seconds;
   logic              before_epoch;

   modport source (
      output valid, year_norm, month_norm, day_norm, hour_norm, minute_norm,
             second_norm, day_of_year, weekday, epoch_seconds, before_epoch,
      input  ready
   );
   modport sink (
      input  valid, year_norm, month_norm, day_norm, hour_norm, minute_norm,
             second_norm, day_of_year, weekday, epoch_seconds, before_epoch,
      output ready
   );
endinterface

>>> rtl/utc_date_to_epoch_seconds_unit.sv
// Top level: pipelined conversion of broken-down UTC time to Unix seconds.
//
// Converts a broken-down UTC time (year since 1900, month, day, hour, minute,
// second, each possibly out of range) into normalised fields, day of year,
// weekday and seconds since 1970-01-01. One request word is taken every clock
// cycle while the pipeline is not stalled; it passes through twelve register
// stages (NUM_STAGES) and its response word is offered from the last stage.
// The depth comes from the carry stages (seconds, minutes, hours), five
// month-adjust stages that each move at most one whole month between the day
// count and the month, and the day-of-year, day-count, 32-bit multiply and
// final weekday fold stages. Every stage has its own valid bit and holds while
// the stage after it is full and cannot advance, so a stalled response still
// lets bubbles further up fill. Years before 1970 give epoch_seconds of all
// ones with before_epoch set; the weekday is still the true calendar weekday.
// Otherwise epoch_seconds wraps modulo 2^32. The block has no configuration
// and no state beyond the pipeline itself.
module utc_date_to_epoch_seconds_unit
   import utce_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   utce_req_if.sink      req_ch,
   utce_rsp_if.source    rsp_ch
);

   item_type             data_ff [NUM_STAGES];
   item_type             data_in [NUM_STAGES];
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] stage_rdy;
   logic [NUM_STAGES-1:0] up_valid;

   // Floor quotient of a narrow value by a small constant divisor; the
   // quotient always lies in -6..5 for the carried ranges.
   function automatic logic signed [3:0] floor_div(input logic signed [10:0] a,
                                                   input int m);
      logic signed [3:0] q;
      q = -4'sd6;
      for (int k = -5; k <= 5; k++) begin
         if (int'(a) >= k * m) begin
            q = 4'(k);
         end
      end
      return q;
   endfunction

   // Move at most one whole month into or out of the day count.
   function automatic item_type month_step(input item_type it);
      item_type   o;
      logic [4:0] len_cur;
      o       = it;
      len_cur = month_len(it.mo, it.yr);
      if (it.dy < 0) begin
         if (it.mo == MONTH_JAN) begin
            o.mo = MONTH_DEC;
            o.yr = 10'(int'(it.yr) - 1);
         end else begin
            o.mo = 4'(it.mo - 4'd1);
         end
         o.dy = 9'(int'(it.dy) + int'(month_len(o.mo, o.yr)));
      end else if (int'(it.dy) >= int'(len_cur)) begin
         o.dy = 9'(int'(it.dy) - int'(len_cur));
         if (it.mo == MONTH_DEC) begin
            o.mo = MONTH_JAN;
            o.yr = 10'(int'(it.yr) + 1);
         end else begin
            o.mo = 4'(it.mo + 4'd1);
         end
      end
      return o;
   endfunction

   // Stage transforms.
   always_comb begin
      item_type          it;
      logic signed [3:0] q;
      logic signed [3:0] qm;
      logic [11:0]       ym1;
      int                n100;
      int                n400;
      logic [16:0]       wsum;
      logic [3:0]        f;

      // Stage 0: decode, carry seconds into minutes and months into years.
      it    = '0;
      q     = floor_div(11'(req_ch.second_raw), SEC_PER_MIN);
      qm    = floor_div(11'(req_ch.month_raw), MONTHS_PER_YEAR);
      it.sc = 6'(int'(req_ch.second_raw) - int'(q) * SEC_PER_MIN);
      it.mn = 10'(int'(req_ch.minute_raw) + int'(q));
      it.hr = 9'(int'(req_ch.hour_raw));
      it.dy = 9'(int'(req_ch.day_of_month_raw) - 1);
      it.mo = 4'(int'(req_ch.month_raw) - int'(qm) * MONTHS_PER_YEAR);
      it.yr = 10'(int'(req_ch.year_since_1900) + int'(qm));
      data_in[0] = it;

      // Stage 1: minutes into hours.
      it    = data_ff[0];
      q     = floor_div(11'(it.mn), MIN_PER_HOUR);
      it.hr = 9'(int'(it.hr) + int'(q));
      it.mn = 10'(int'(it.mn) - int'(q) * MIN_PER_HOUR);
      data_in[1] = it;

      // Stage 2: hours into days.
      it    = data_ff[1];
      q     = floor_div(11'(it.hr), HOUR_PER_DAY);
      it.dy = 9'(int'(it.dy) + int'(q));
      it.hr = 9'(int'(it.hr) - int'(q) * HOUR_PER_DAY);
      data_in[2] = it;

      // Stages 3 to 7: one month adjustment each.
      for (int k = MSTEP_FIRST; k <= MSTEP_LAST; k++) begin
         data_in[k] = month_step(data_ff[k-1]);
      end

      // Stage 8: day of year, year offset, leap-day count, time of day.
      it      = data_ff[MSTEP_LAST];
      it.yday = 9'(int'(it.dy) + int'(CUM_DAYS[it.mo]) +
                   ((it.mo > MONTH_FEB && is_leap(it.yr)) ? 1 : 0));
      it.ydiff = 9'(int'(it.yr) - EPOCH_YEAR_OFS);
      ym1     = 12'(int'(it.yr) + YEAR_M1_BASE);
      n100    = ((it.yr >= 10'sd1) ? 1 : 0) +
                ((it.yr > 10'(CENTURY_2000)) ? 1 : 0) +
                ((it.yr > 10'(CENTURY_2100)) ? 1 : 0);
      n400    = (it.yr > 10'(CENTURY_2000)) ? 1 : 0;
      it.leapd  = 7'(int'(ym1[11:2]) - LEAP_BASE - n100 + n400);
      it.tod    = 17'(SEC_PER_HOUR * int'(it.hr[4:0]) +
                      SEC_PER_MIN * int'(it.mn[5:0]) + int'(it.sc));
      it.pre_epoch = it.yr < 10'(EPOCH_YEAR_OFS);
      data_in[8] = it;

      // Stage 9: days since 1970.
      it       = data_ff[8];
      it.total = 18'(int'(it.yday) + DAYS_PER_YEAR * int'(it.ydiff) + int'(it.leapd));
      data_in[9] = it;

      // Stage 10: day seconds product, first weekday fold (8 is 1 mod 7).
      it      = data_ff[9];
      it.prod = 32'(it.total) * 32'(SEC_PER_DAY);
      wsum    = 17'(int'(it.total) + WDAY_EPOCH + WDAY_BIAS);
      it.wfold = 6'(int'(wsum[2:0]) + int'(wsum[5:3]) + int'(wsum[8:6]) +
                    int'(wsum[11:9]) + int'(wsum[14:12]) + int'(wsum[16:15]));
      data_in[10] = it;

      // Stage 11: final weekday fold and epoch seconds.
      it = data_ff[10];
      f  = 4'(int'(it.wfold[2:0]) + int'(it.wfold[5:3]));
      if (int'(f) >= DAYS_PER_WEEK) begin
         f = 4'(int'(f) - DAYS_PER_WEEK);
      end
      if (int'(f) >= DAYS_PER_WEEK) begin
         f = 4'(int'(f) - DAYS_PER_WEEK);
      end
      it.wday = f[2:0];
      it.secs = it.pre_epoch ? '1 : (it.prod + 32'(it.tod));
      data_in[11] = it;
   end

   // A stage takes a word when it is empty or the stage after it advances.
   always_comb begin
      up_valid = {valid_ff[NUM_STAGES-2:0], req_ch.valid};
      stage_rdy[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ch.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
      end
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (stage_rdy[k]) begin
            valid_in[k] = up_valid[k];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload: advance only where a valid word moves in, else hold.
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (stage_rdy[k] && up_valid[k]) begin
            data_ff[k] <= data_in[k];
         end
      end
   end

   assign req_ch.ready = stage_rdy[0];

   assign rsp_ch.valid         = valid_ff[NUM_STAGES-1];
   assign rsp_ch.year_norm     = data_ff[NUM_STAGES-1].yr;
   assign rsp_ch.month_norm    = data_ff[NUM_STAGES-1].mo;
   assign rsp_ch.day_norm      = 5'(data_ff[NUM_STAGES-1].dy + 9'sd1);
   assign rsp_ch.hour_norm     = data_ff[NUM_STAGES-1].hr[4:0];
   assign rsp_ch.minute_norm   = data_ff[NUM_STAGES-1].mn[5:0];
   assign rsp_ch.second_norm   = data_ff[NUM_STAGES-1].sc;
   assign rsp_ch.day_of_year   = data_ff[NUM_STAGES-1].yday;
   assign rsp_ch.weekday       = data_ff[NUM_STAGES-1].wday;
   assign rsp_ch.epoch_seconds = data_ff[NUM_STAGES-1].secs;
   assign rsp_ch.before_epoch  = data_ff[NUM_STAGES-1].pre_epoch;

endmodule

>>> rtl/utce_checker.sv
// Checker: port-level assertions for the UTC to epoch unit, bound to the top level.
module utce_checker
   import utce_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [9:0] rsp_year_norm,
   input logic [2:0]        rsp_weekday,
   input logic [31:0]       rsp_epoch_seconds,
   input logic              rsp_before_epoch
);

   logic [4:0] cnt_ff;
   logic [4:0] cnt_in;

   // Track words in flight.
   always_comb begin
      cnt_in = 5'(cnt_ff + 5'(req_valid && req_ready) - 5'(rsp_valid && rsp_ready));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_epoch_seconds) &&
                                  $stable(rsp_weekday))
      else $error("response word changed while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != 5'd0)
      else $error("response word with no request word in flight");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 5'(NUM_STAGES))
      else $error("more words in flight than pipeline stages");

   a_before: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_before_epoch |->
         rsp_epoch_seconds == '1 && rsp_year_norm < 10'(EPOCH_YEAR_OFS))
      else $error("pre-1970 word without saturated seconds");

endmodule

bind utc_date_to_epoch_seconds_unit utce_checker u_utce_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_year_norm     (rsp_ch.year_norm),
   .rsp_weekday       (rsp_ch.weekday),
   .rsp_epoch_seconds (rsp_ch.epoch_seconds),
   .rsp_before_epoch  (rsp_ch.before_epoch)
);

>>> bench/utc_date_to_epoch_seconds_unit_tb.sv
// Testbench: random and directed UTC date words through the epoch-seconds unit.
`timescale 1ns / 100ps

module utc_date_to_epoch_seconds_unit_tb;
   import utce_pkg::*;

   // One request word as the block sees it.
   typedef struct packed {
      logic [7:0]        year_since_1900;
      logic signed [6:0] month_raw;
      logic signed [7:0] day_of_month_raw;
      logic signed [7:0] hour_raw;
      logic signed [8:0] minute_raw;
      logic signed [8:0] second_raw;
   } date_word_type;

   // One response word at the block's output widths.
   typedef struct packed {
      logic signed [9:0] year_norm;
      logic [3:0]        month_norm;
      logic [4:0]        day_norm;
      logic [4:0]        hour_norm;
      logic [5:0]        minute_norm;
      logic [5:0]        second_norm;
      logic [8:0]        day_of_year;
      logic [2:0]        weekday;
      logic [31:0]       epoch_seconds;
      logic              before_epoch;
   } epoch_word_type;

   localparam int RANDOM_WORDS     = 1880;
   localparam int QUIET_TAIL       = 200;   // last words run with no idling at all
   localparam int PHASE_LEN        = 160;   // words per idling phase
   localparam int HOLD_AT_WORD     = 600;   // start the long receiver hold here
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int DRAIN_CYCLES     = 3 * NUM_STAGES;
   localparam int TIMEOUT_NS       = 5_000_000;

   // Days before the start of each month in a common year.
   localparam int MONTH_START [13] = '{
      0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
   };

   // Years (minus 1900) around the epoch, the centuries and the 32-bit wrap.
   localparam int YEAR_HOTSPOTS [15] = '{
      0, 1, 69, 70, 71, 99, 100, 101, 138, 199, 200, 201, 206, 254, 255
   };

   logic clock;
   logic reset;

   utce_req_if req_ch ();
   utce_rsp_if rsp_ch ();

   utc_date_to_epoch_seconds_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   date_word_type  pending_dates [$];
   epoch_word_type expected_epochs [$];

   int total_words  = 0;
   int words_sent   = 0;   // advanced with nonblocking writes only
   int results_seen = 0;   // advanced with nonblocking writes only
   int error_count  = 0;
   int send_gap     = 0;
   int sink_stall   = 0;
   int hold_cycles  = 0;
   logic rsp_hold   = 1'b0;

   // ------------------------------------------------------------------
   // Calendar arithmetic, floor-based so negative fields borrow upwards.
   // ------------------------------------------------------------------
   function automatic int floor_div(int a, int m);
      int q;
      q = a / m;
      if ((a % m) < 0)
         q--;
      return q;
   endfunction

   function automatic int floor_mod(int a, int m);
      int r;
      r = a % m;
      if (r < 0)
         r += m;
      return r;
   endfunction

   function automatic bit leap_year(int y);
      return (floor_mod(y, 4) == 0 && floor_mod(y, 100) != 0) || floor_mod(y, 400) == 0;
   endfunction

   function automatic int days_in_month(int m, int y);
      return MONTH_START[m + 1] - MONTH_START[m] + ((m == 1 && leap_year(y)) ? 1 : 0);
   endfunction

   // Leap years from year 1 up to y-1.
   function automatic int leaps_through(int y);
      return floor_div(y - 1, 4) - floor_div(y - 1, 100) + floor_div(y - 1, 400);
   endfunction

   // Normalise a date word and work out day of year, weekday and Unix seconds.
   function automatic epoch_word_type convert_utc(date_word_type d);
      epoch_word_type r;
      int yr, mo, dy, hr, mn, sc;
      int yday, total;
      logic [31:0] secs;
      yr = int'(d.year_since_1900) + 1900;
      mo = int'(d.month_raw);
      dy = int'(d.day_of_month_raw) - 1;
      hr = int'(d.hour_raw);
      mn = int'(d.minute_raw);
      sc = int'(d.second_raw);

      // carry seconds up through minutes and hours into days, months into years
      mn += floor_div(sc, 60);  sc = floor_mod(sc, 60);
      hr += floor_div(mn, 60);  mn = floor_mod(mn, 60);
      dy += floor_div(hr, 24);  hr = floor_mod(hr, 24);
      yr += floor_div(mo, 12);  mo = floor_mod(mo, 12);

      // move whole months between the day count and the month
      while (dy < 0) begin
         mo--;
         if (mo < 0) begin
            mo = 11;
            yr--;
         end
         dy += days_in_month(mo, yr);
      end
      while (dy >= days_in_month(mo, yr)) begin
         dy -= days_in_month(mo, yr);
         mo++;
         if (mo >= 12) begin
            mo = 0;
            yr++;
         end
      end

      yday  = dy + MONTH_START[mo] + ((mo > 1 && leap_year(yr)) ? 1 : 0);
      total = yday + 365 * (yr - 1970) + (leaps_through(yr) - leaps_through(1970));

      if (yr < 1970)
         secs = 32'hFFFF_FFFF;
      else
         secs = 32'd86400 * 32'(total) + 32'd3600 * 32'(hr) + 32'd60 * 32'(mn) + 32'(sc);

      r.year_norm     = 10'(yr - 1900);
      r.month_norm    = 4'(mo);
      r.day_norm      = 5'(dy + 1);
      r.hour_norm     = 5'(hr);
      r.minute_norm   = 6'(mn);
      r.second_norm   = 6'(sc);
      r.day_of_year   = 9'(yday);
      r.weekday       = 3'(floor_mod(total + 4, 7));
      r.epoch_seconds = secs;
      r.before_epoch  = (yr < 1970);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------
   function automatic int pick(int lo, int hi);
      return lo + int'($urandom_range(hi - lo, 0));
   endfunction

   task automatic add_date(int y, int mo, int d, int h, int mi, int s);
      date_word_type w;
      w.year_since_1900  = 8'(y);
      w.month_raw        = 7'(mo);
      w.day_of_month_raw = 8'(d);
      w.hour_raw         = 8'(h);
      w.minute_raw       = 9'(mi);
      w.second_raw       = 9'(s);
      pending_dates.insert(pending_dates.size(), w);
   endtask

   task automatic report(string what);
      $display("%0t ns: MISMATCH %s", $time, what);
      error_count++;
   endtask

   task automatic check_field(int idx, string name, longint got, longint want);
      if (got != want)
         report($sformatf("word %0d %s: got %0d, want %0d", idx, name, got, want));
   endtask

   // Idling phases: sender and receiver idle in different phases so every
   // combination turns up; the tail and the long hold run with the sender busy.
   function automatic bit sender_may_idle();
      return ((words_sent / PHASE_LEN) % 3 != 0) && (words_sent < total_words - QUIET_TAIL)
             && !rsp_hold;
   endfunction

   function automatic bit sink_may_idle();
      return ((results_seen / PHASE_LEN) % 3 != 1) && (results_seen < total_words - QUIET_TAIL);
   endfunction

   // ------------------------------------------------------------------
   // Clock, reset, stimulus list and end of run.
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int kind;
      int y;
      // hold reset from the start; the driver and monitor clear the bus
      reset = 1'b1;

      // directed words
      add_date(70, 0, 1, 0, 0, 0);            // the epoch itself
      add_date(69, 11, 31, 23, 59, 59);       // last second before the epoch
      add_date(70, 0, 1, 0, 0, -1);           // borrow back across the epoch
      add_date(100, 1, 29, 12, 0, 0);         // 2000 is a leap year
      add_date(0, 1, 29, 0, 0, 0);            // 1900 is not: rolls to 1 March
      add_date(200, 1, 29, 0, 0, 0);          // nor is 2100
      add_date(104, 11, 31, 23, 59, 59);      // last day of a leap year
      add_date(138, 0, 19, 3, 14, 7);         // top of signed 32-bit seconds
      add_date(206, 1, 7, 6, 28, 16);         // seconds wrap past 2^32
      add_date(255, 11, 31, 23, 59, 59);      // latest year
      add_date(0, -24, -62, -48, -120, -120); // lows of the usual ranges
      add_date(255, 35, 93, 71, 179, 179);    // highs of the usual ranges
      add_date(0, -64, -128, -128, -256, -256); // most negative bit patterns
      add_date(255, 63, 127, 127, 255, 255);  // most positive bit patterns
      add_date(70, 0, 0, 0, 0, 0);            // day zero drops into 1969
      add_date(124, 2, 0, 0, 0, 0);           // day zero of March in a leap year
      add_date(123, 12, 1, 0, 0, 0);          // month twelve carries a year
      add_date(70, -1, 1, 0, 0, 0);           // negative month borrows a year
      add_date(99, 11, 31, 24, 0, 0);         // hour carry into a new century
      add_date(100, 0, 1, 0, 60, 0);          // minute carry
      add_date(71, 0, 1, -1, 0, 0);           // negative hour borrows a day
      add_date(130, 6, 15, 12, 30, 30);       // plain mid-year date

      // random words: mostly the usual ranges, some tidy dates, some raw bits
      repeat (RANDOM_WORDS) begin
         kind = pick(0, 99);
         if (pick(0, 3) == 0)
            y = YEAR_HOTSPOTS[pick(0, 14)];
         else
            y = pick(0, 255);
         if (kind < 60)
            add_date(y, pick(-24, 35), pick(-62, 93), pick(-48, 71),
                     pick(-120, 179), pick(-120, 179));
         else if (kind < 80)
            add_date(y, pick(0, 11), (pick(0, 1) != 0) ? pick(27, 31) : pick(1, 31),
                     pick(0, 23), pick(0, 59), pick(0, 59));
         else
            add_date(y, pick(-64, 63), pick(-128, 127), pick(-128, 127),
                     pick(-256, 255), pick(-256, 255));
      end
      total_words = pending_dates.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // drain, then allow for any stray word the pipeline might still push out
      wait (words_sent == total_words && results_seen == total_words);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("utc_date_to_epoch_seconds_unit_tb: done, clean");
      else
         $display("utc_date_to_epoch_seconds_unit_tb: done, errors");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("utc_date_to_epoch_seconds_unit_tb: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------
   // Driver: offer the head of the pending list, hold it until taken.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid            <= 1'b0;
         req_ch.year_since_1900  <= '0;
         req_ch.month_raw        <= '0;
         req_ch.day_of_month_raw <= '0;
         req_ch.hour_raw         <= '0;
         req_ch.minute_raw       <= '0;
         req_ch.second_raw       <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            // the word went in at this edge: predict its result and drop it
            expected_epochs.insert(expected_epochs.size(),
                                   convert_utc(pending_dates.pop_front()));
            words_sent <= words_sent + 1;
            if (sender_may_idle() && pick(0, 99) < 18)
               send_gap = pick(1, 9);
         end
         // a refused word stays on the bus unchanged
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_dates.size() > 0) begin
               req_ch.valid            <= 1'b1;
               req_ch.year_since_1900  <= pending_dates[0].year_since_1900;
               req_ch.month_raw        <= pending_dates[0].month_raw;
               req_ch.day_of_month_raw <= pending_dates[0].day_of_month_raw;
               req_ch.hour_raw         <= pending_dates[0].hour_raw;
               req_ch.minute_raw       <= pending_dates[0].minute_raw;
               req_ch.second_raw       <= pending_dates[0].second_raw;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Long receiver hold: once, partway in, keep ready low long enough for
   // the pipeline to fill and push back on the sender.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold <= 1'b0;
         hold_cycles = 0;
      end else if (rsp_hold) begin
         hold_cycles++;
         if (hold_cycles >= LONG_HOLD_CYCLES)
            rsp_hold <= 1'b0;
      end else if (hold_cycles == 0 && words_sent >= HOLD_AT_WORD) begin
         rsp_hold <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check each taken response against the oldest prediction and
   // drive ready with random stall bursts.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      epoch_word_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         sink_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            // words_sent still holds its value from before this edge, so a
            // response can only match a request taken at an earlier edge
            if (results_seen >= words_sent) begin
               report($sformatf("response word with nothing outstanding (seen %0d)",
                                results_seen));
            end else begin
               want = expected_epochs.pop_front();
               check_field(results_seen, "year_norm", rsp_ch.year_norm, want.year_norm);
               check_field(results_seen, "month_norm", rsp_ch.month_norm, want.month_norm);
               check_field(results_seen, "day_norm", rsp_ch.day_norm, want.day_norm);
               check_field(results_seen, "hour_norm", rsp_ch.hour_norm, want.hour_norm);
               check_field(results_seen, "minute_norm", rsp_ch.minute_norm,
                           want.minute_norm);
               check_field(results_seen, "second_norm", rsp_ch.second_norm,
                           want.second_norm);
               check_field(results_seen, "day_of_year", rsp_ch.day_of_year,
                           want.day_of_year);
               check_field(results_seen, "weekday", rsp_ch.weekday, want.weekday);
               check_field(results_seen, "epoch_seconds", rsp_ch.epoch_seconds,
                           want.epoch_seconds);
               check_field(results_seen, "before_epoch", rsp_ch.before_epoch,
                           want.before_epoch);
               results_seen <= results_seen + 1;
            end
         end
         if (sink_stall > 0)
            sink_stall--;
         else if (sink_may_idle() && pick(0, 99) < 15)
            sink_stall = pick(1, 9);
         rsp_ch.ready <= (sink_stall == 0) && !rsp_hold;
      end
   end

endmodule

>>> files.f
rtl/utce_pkg.sv
rtl/utce_req_if.sv
rtl/utce_rsp_if.sv
rtl/utc_date_to_epoch_seconds_unit.sv
rtl/utce_checker.sv
bench/utc_date_to_epoch_seconds_unit_tb.sv
